@@ design/efb_pkg.sv @@
package efb_pkg;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [23:0]        example_id;
    logic               final_item;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [23:0]        bin_number;
    logic [23:0]        example_out;
    logic signed [31:0] threshold;
    logic [23:0]        tally;
    logic               no_binning;
    logic               last_of_run;
  } out_item_t;

  localparam logic [2:0] KIND_INDEX  = 3'd0;
  localparam logic [2:0] KIND_THRESH = 3'd1;
  localparam logic [2:0] KIND_DROP   = 3'd2;
  localparam logic [2:0] KIND_SPARSE = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  localparam logic [2:0] REG_BIN_RATIO    = 3'd0;
  localparam logic [2:0] REG_MIN_BINS     = 3'd1;
  localparam logic [2:0] REG_MAX_BINS     = 3'd2;
  localparam logic [2:0] REG_NUM_EXAMPLES = 3'd3;
  localparam logic [2:0] REG_NUM_DENSE    = 3'd4;
  localparam logic [2:0] REG_SPARSE_LEVEL = 3'd5;
  localparam logic [2:0] REG_SPARSE_MODE  = 3'd6;

  localparam int ADDR_BITS = 5;

endpackage

@@ design/efb_div.sv @@
module efb_div #(
  parameter int NW = 26,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW+1:0]   trial;
  logic            fits;

  assign trial = {rem, quot[NW-1]};
  assign fits  = trial >= {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      rem   <= '0;
      quot  <= num;
      den_r <= den;
      cnt   <= CNTW'(NW);
    end else if (busy) begin
      rem  <= fits ? (DW+1)'(trial - {2'b00, den_r}) : trial[DW:0];
      quot <= {quot[NW-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

@@ design/equal_frequency_binner_core.sv @@
// Sequence: the first item of a feature also runs the multiply, the clamp and
//   the bit-serial divide for values per bin (no divide with fewer than two
//   bins); later items of the feature skip them.
// Throughput: one item at a time; results leave one per cycle while out_ready
//   is high, through the output register, up to five per item, each emit state waits for it.
// Reset: rst (synchronous) restores register defaults and idles the sequencer.
module equal_frequency_binner_core #(
  parameter int COUNT_BITS = 24,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  efb_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output efb_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efb_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import efb_pkg::*;

  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int CW = COUNT_BITS;
  localparam int SW = ((CW > 24) ? CW : 24) + 1;
  localparam logic [SW-1:0] CMAX = SW'((64'd1 << CW) - 64'd1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL   = 12'b000000000010,
    S_CLAMP = 12'b000000000100,
    S_DIV   = 12'b000000001000,
    S_CHECK = 12'b000000010000,
    S_BND1  = 12'b000000100000,
    S_BND2  = 12'b000001000000,
    S_SKIP  = 12'b000010000000,
    S_BIN   = 12'b000100000000,
    S_IDX   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_BELOW = 3'b001,
    PH_SKIP  = 3'b010,
    PH_ABOVE = 3'b100
  } phase_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic [SW-1:0] x);
    return (x > CMAX) ? '1 : x[CW-1:0];
  endfunction

  function automatic logic [23:0] to24(input logic [CW-1:0] x);
    logic [SW-1:0] t;
    t = SW'(x);
    return t[23:0];
  endfunction

  // configuration
  logic [15:0]        bin_ratio;
  logic [23:0]        min_bins, max_bins, num_examples, num_dense;
  logic [31:0]        sparse_level;
  logic               sparse_mode;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_ratio    <= 16'd21627;
      min_bins     <= 24'd2;
      max_bins     <= 24'd0;
      num_examples <= 24'd1;
      num_dense    <= 24'd1;
      sparse_level <= 32'd0;
      sparse_mode  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_BIN_RATIO:    bin_ratio    <= pwdata[15:0];
        REG_MIN_BINS:     min_bins     <= pwdata[23:0];
        REG_MAX_BINS:     max_bins     <= pwdata[23:0];
        REG_NUM_EXAMPLES: num_examples <= pwdata[23:0];
        REG_NUM_DENSE:    num_dense    <= pwdata[23:0];
        REG_SPARSE_LEVEL: sparse_level <= pwdata;
        REG_SPARSE_MODE:  sparse_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BIN_RATIO:    prdata = {16'd0, bin_ratio};
      REG_MIN_BINS:     prdata = {8'd0, min_bins};
      REG_MAX_BINS:     prdata = {8'd0, max_bins};
      REG_NUM_EXAMPLES: prdata = {8'd0, num_examples};
      REG_NUM_DENSE:    prdata = {8'd0, num_dense};
      REG_SPARSE_LEVEL: prdata = sparse_level;
      REG_SPARSE_MODE:  prdata = {31'd0, sparse_mode};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t              state;
  phase_t              phase;
  logic                started, bnd_final;
  logic signed [VW-1:0] cur_v, prev_value;
  logic [23:0]         cur_id;
  logic                cur_fin;
  logic [39:0]         prod;
  logic [CW-1:0]       fill_count, bin_counter, per_bin, bins_planned;

  // planning
  logic [40:0]   bsum;
  logic [24:0]   b0, b1, b2;
  logic [CW-1:0] bins_c;
  logic [SW:0]   div_num, div_quot;
  logic          div_start, div_done;

  assign bsum   = {1'b0, prod} + 41'h0FFFF;
  assign b0     = bsum[40:16];
  assign b1     = (b0 < {1'b0, min_bins}) ? {1'b0, min_bins} : b0;
  assign b2     = (max_bins != 24'd0 && b1 > {1'b0, max_bins}) ? {1'b0, max_bins} : b1;
  assign bins_c = clamp(SW'(b2));
  assign div_num = (SW+1)'(num_dense) + (SW+1)'(bins_c) - (SW+1)'(1);
  assign div_start = (state == S_CLAMP) && (bins_c > CW'(1));

  efb_div #(.NW(SW + 1), .DW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (SW'(bins_c)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared compare / mean unit
  logic signed [VW-1:0] sl_v, mean_b;
  logic signed [VW:0]   msum;
  logic signed [VW-1:0] mean_v;
  logic [23:0]          nsp;
  logic                 full, bin_phase, room, emit_en, adv;
  out_item_t            emit_item;

  assign sl_v      = sparse_level[VW-1:0];
  assign mean_b    = (state == S_BND1) ? sl_v : cur_v;
  assign msum      = {prev_value[VW-1], prev_value} + {mean_b[VW-1], mean_b};
  assign mean_v    = msum[VW:1];
  assign nsp       = (num_examples > num_dense) ? num_examples - num_dense : 24'd0;
  assign full      = fill_count >= per_bin;
  assign bin_phase = (phase == PH_BELOW) || (phase == PH_ABOVE);
  assign room      = !out_valid || out_ready;
  assign adv       = !emit_en || room;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    emit_en   = 1'b0;
    emit_item = '0;
    case (state)
      S_BND1: begin
        emit_en = sparse_mode;
        emit_item.bin_number = to24(bin_counter);
        if (full) begin
          emit_item.kind      = KIND_THRESH;
          emit_item.threshold = 32'(mean_v);
        end else begin
          emit_item.kind  = KIND_DROP;
          emit_item.tally = to24(fill_count);
        end
      end
      S_BND2: begin
        emit_en = 1'b1;
        emit_item.kind        = KIND_SPARSE;
        emit_item.bin_number  = to24(bin_counter);
        emit_item.last_of_run = !cur_fin && sparse_mode && (cur_v == sl_v);
      end
      S_BIN: begin
        emit_en = bin_phase && (cur_v != prev_value) && full;
        emit_item.kind       = KIND_THRESH;
        emit_item.bin_number = to24(bin_counter);
        emit_item.threshold  = 32'(mean_v);
      end
      S_IDX: begin
        emit_en = 1'b1;
        emit_item.kind        = KIND_INDEX;
        emit_item.bin_number  = to24(bin_counter);
        emit_item.example_out = cur_id;
        emit_item.last_of_run = !cur_fin;
      end
      S_DONE: begin
        emit_en = 1'b1;
        emit_item.kind        = KIND_DONE;
        emit_item.last_of_run = 1'b1;
        if (bins_planned <= CW'(1)) begin
          emit_item.tally      = 24'd1;
          emit_item.no_binning = 1'b1;
        end else begin
          emit_item.tally      = to24(sat_inc(bin_counter));
          emit_item.no_binning = (bin_counter == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en && room) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_en && room) begin
      out_data <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_BELOW;
      started      <= 1'b0;
      bnd_final    <= 1'b0;
      fill_count   <= '0;
      bin_counter  <= '0;
      per_bin      <= '0;
      bins_planned <= '0;
      prev_value   <= '0;
    end else if (adv) begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_v   <= in_data.sample_value[VW-1:0];
            cur_id  <= in_data.example_id;
            cur_fin <= in_data.final_item;
            state   <= started ? S_CHECK : S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 40'(bin_ratio) * 40'(num_examples);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          bins_planned <= bins_c;
          fill_count   <= '0;
          bin_counter  <= '0;
          phase        <= PH_BELOW;
          prev_value   <= sl_v;
          started      <= 1'b1;
          if (bins_c > CW'(1)) begin
            state <= S_DIV;
          end else begin
            per_bin <= '0;
            state   <= S_CHECK;
          end
        end
        S_DIV: begin
          if (div_done) begin
            per_bin <= (div_quot > (SW+1)'(CMAX)) ? '1 : div_quot[CW-1:0];
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (bins_planned <= CW'(1)) begin
            state <= cur_fin ? S_DONE : S_IDLE;
          end else if (phase == PH_BELOW && !(cur_v < sl_v)) begin
            bnd_final <= 1'b0;
            state     <= S_BND1;
          end else begin
            state <= S_SKIP;
          end
        end
        S_BND1: begin
          if (sparse_mode) begin
            if (full) begin
              fill_count  <= clamp(SW'(nsp));
              bin_counter <= sat_inc(bin_counter);
            end else begin
              fill_count <= clamp(SW'(fill_count) + SW'(nsp));
            end
            prev_value <= sl_v;
            phase      <= PH_SKIP;
          end else begin
            phase <= PH_ABOVE;
          end
          state <= S_BND2;
        end
        S_BND2: begin
          state <= bnd_final ? S_DONE : S_SKIP;
        end
        S_SKIP: begin
          if (phase == PH_SKIP) begin
            if (cur_v == prev_value) begin
              fill_count <= sat_inc(fill_count);
            end else begin
              phase <= PH_ABOVE;
            end
          end
          state <= S_BIN;
        end
        S_BIN: begin
          if (bin_phase) begin
            if (cur_v != prev_value) begin
              if (full) begin
                fill_count  <= '0;
                bin_counter <= sat_inc(bin_counter);
              end
              prev_value <= cur_v;
            end
            state <= S_IDX;
          end else begin
            state <= S_FIN;
          end
        end
        S_IDX: begin
          fill_count <= sat_inc(fill_count);
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!cur_fin) begin
            state <= S_IDLE;
          end else if (phase == PH_BELOW) begin
            bnd_final <= 1'b1;
            state     <= S_BND1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          started <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/efb_checker.sv @@
module efb_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input efb_pkg::out_item_t out_data
);
  import efb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kind <= KIND_DONE)
    else $error("undefined result kind");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last_of_run)
    else $error("done transfer not last of run");

  a_nobin_tally: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE && out_data.no_binning |->
      out_data.tally == 24'd1)
    else $error("no binning with tally other than one");
endmodule

bind equal_frequency_binner_core efb_checker u_efb_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efb_pkg::*;

  localparam longint CMAX      = 64'hFFFFFF;
  localparam int     SETTLE    = 40;
  localparam int     MAX_CYCLE = 400000;

  typedef enum logic [1:0] {PH_BELOW, PH_SKIP, PH_ABOVE} phase_t;

  class bin_scoreboard;
    longint    regs [7];
    phase_t    phase;
    longint    prev_value;
    longint    fill_count, bin_counter, index_counter, per_bin, bins_planned;
    bit        started;
    out_item_t pending_q[$];
    out_item_t run_q[$];
    int        errors, results_seen, items_seen;

    function new();
      regs[REG_BIN_RATIO]    = 21627;
      regs[REG_MIN_BINS]     = 2;
      regs[REG_MAX_BINS]     = 0;
      regs[REG_NUM_EXAMPLES] = 1;
      regs[REG_NUM_DENSE]    = 1;
      regs[REG_SPARSE_LEVEL] = 0;
      regs[REG_SPARSE_MODE]  = 0;
      started = 0;
      errors = 0;
    endfunction

    function longint sat_add(longint a, longint b);
      return (a + b > CMAX) ? CMAX : a + b;
    endfunction

    function longint level();
      logic signed [31:0] l;
      l = regs[REG_SPARSE_LEVEL][31:0];
      return longint'(l);
    endfunction

    function logic [31:0] midpoint(longint a, longint b);
      longint s;
      s = (a + b) >>> 1;
      return s[31:0];
    endfunction

    function void push(logic [2:0] k, longint bin, longint ex, logic [31:0] thr,
                       longint tally, logic nob);
      out_item_t o;
      if (run_q.size() >= 6) return;
      o = '0;
      o.kind = k;
      o.bin_number = bin[23:0];
      o.example_out = ex[23:0];
      o.threshold = thr;
      o.tally = tally[23:0];
      o.no_binning = nob;
      run_q.push_back(o);
    endfunction

    function void plan_bins();
      longint b;
      b = (regs[REG_BIN_RATIO] * regs[REG_NUM_EXAMPLES] + 65535) >> 16;
      if (b < regs[REG_MIN_BINS]) b = regs[REG_MIN_BINS];
      if (regs[REG_MAX_BINS] != 0 && b > regs[REG_MAX_BINS]) b = regs[REG_MAX_BINS];
      if (b > CMAX) b = CMAX;
      bins_planned = b;
      per_bin = (b > 1) ? (regs[REG_NUM_DENSE] + b - 1) / b : 0;
      if (per_bin > CMAX) per_bin = CMAX;
      prev_value = level();
      fill_count = 0;
      bin_counter = 0;
      index_counter = 0;
      phase = PH_BELOW;
      started = 1;
    endfunction

    function void close_at_sparse();
      longint sv, nsp;
      if (regs[REG_SPARSE_MODE] != 0) begin
        sv = level();
        nsp = regs[REG_NUM_EXAMPLES] > regs[REG_NUM_DENSE] ?
              regs[REG_NUM_EXAMPLES] - regs[REG_NUM_DENSE] : 0;
        if (fill_count >= per_bin) begin
          push(KIND_THRESH, bin_counter, 0, midpoint(prev_value, sv), 0, 0);
          fill_count = nsp > CMAX ? CMAX : nsp;
          bin_counter = sat_add(bin_counter, 1);
        end else begin
          push(KIND_DROP, bin_counter, 0, 0, fill_count, 0);
          index_counter = fill_count > index_counter ? 0 : index_counter - fill_count;
          fill_count = sat_add(fill_count, nsp);
        end
        prev_value = sv;
        phase = PH_SKIP;
      end else begin
        phase = PH_ABOVE;
      end
      push(KIND_SPARSE, bin_counter, 0, 0, 0, 0);
    endfunction

    function void place_value(longint v, longint id);
      if (v != prev_value) begin
        if (fill_count >= per_bin) begin
          push(KIND_THRESH, bin_counter, 0, midpoint(prev_value, v), 0, 0);
          fill_count = 0;
          bin_counter = sat_add(bin_counter, 1);
        end
        prev_value = v;
      end
      push(KIND_INDEX, bin_counter, id, 0, 0, 0);
      fill_count = sat_add(fill_count, 1);
      index_counter = sat_add(index_counter, 1);
    endfunction

    function void note_input(in_item_t it);
      longint v, id;
      v = longint'(it.sample_value);
      id = it.example_id;
      run_q.delete();
      items_seen++;
      if (!started) plan_bins();
      if (bins_planned <= 1) begin
        if (it.final_item) begin
          push(KIND_DONE, 0, 0, 0, 1, 1);
          started = 0;
        end
      end else begin
        if (phase == PH_BELOW && !(v < level())) close_at_sparse();
        if (phase == PH_SKIP) begin
          if (v == prev_value) fill_count = sat_add(fill_count, 1);
          else phase = PH_ABOVE;
        end
        if (phase != PH_SKIP) place_value(v, id);
        if (it.final_item) begin
          if (phase == PH_BELOW) close_at_sparse();
          push(KIND_DONE, 0, 0, 0, sat_add(bin_counter, 1), bin_counter == 0);
          started = 0;
        end
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1;
      foreach (run_q[i]) pending_q.push_back(run_q[i]);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
      errors++;
    endtask

    task check_result(out_item_t o);
      out_item_t w;
      results_seen++;
      if (pending_q.size() == 0) begin
        report("unexpected transfer, kind", o.kind, 0);
        return;
      end
      w = pending_q.pop_front();
      if (o.kind != w.kind) report("kind", o.kind, w.kind);
      if (o.bin_number != w.bin_number) report("bin_number", o.bin_number, w.bin_number);
      if (o.example_out != w.example_out) report("example_out", o.example_out, w.example_out);
      if (o.threshold != w.threshold) report("threshold", o.threshold, w.threshold);
      if (o.tally != w.tally) report("tally", o.tally, w.tally);
      if (o.no_binning != w.no_binning) report("no_binning", o.no_binning, w.no_binning);
      if (o.last_of_run != w.last_of_run) report("last_of_run", o.last_of_run, w.last_of_run);
    endtask
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  out_item_t  out_data;
  logic       psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;

  bin_scoreboard sb = new();
  int  cycles = 0;
  int  hold_off = 0;
  int  rx_wait = 0;
  bit  rx_fired = 0;
  bit  rx_eager = 0;
  bit  tx_eager = 0;
  int  features = 0;

  equal_frequency_binner_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("equal_frequency_binner_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
      rx_fired = 1;
    end
  end

  always @(negedge clk) begin
    if (rx_fired) begin
      rx_wait = rx_eager ? 0 : $urandom_range(0, 3);
      rx_fired = 0;
    end
    if (hold_off > 0) begin
      hold_off--;
      out_ready = 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready = 0;
    end else begin
      out_ready = 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = ADDR_BITS'(idx) << 2;
    pwdata = val[31:0];
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    sb.regs[idx] = val;
  endtask

  task automatic send_item(logic signed [31:0] v, logic [23:0] id, logic fin);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data.sample_value = v;
    in_data.example_id = id;
    in_data.final_item = fin;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_feature(longint ratio, longint minb, longint maxb, longint nex,
                             longint nd, longint lvl, longint mode);
    write_reg(REG_BIN_RATIO, ratio);
    write_reg(REG_MIN_BINS, minb);
    write_reg(REG_MAX_BINS, maxb);
    write_reg(REG_NUM_EXAMPLES, nex);
    write_reg(REG_NUM_DENSE, nd);
    write_reg(REG_SPARSE_LEVEL, lvl);
    write_reg(REG_SPARSE_MODE, mode);
  endtask

  function automatic longint clamp32(longint x);
    if (x < -64'sd2147483648) return -64'sd2147483648;
    if (x > 64'sd2147483647) return 64'sd2147483647;
    return x;
  endfunction

  // ascending run: some below the sparse level, some equal, rest above
  task automatic stream_sorted(int n, longint lvl, bit noisy);
    longint vals[$];
    longint v, scale;
    int nb, ne;
    nb = $urandom_range(0, n);
    ne = $urandom_range(0, n - nb);
    case ($urandom_range(0, 2))
      0: scale = 1;
      1: scale = 65536;
      default: scale = $urandom_range(1, 1 << 26);
    endcase
    v = lvl;
    for (int i = 0; i < nb; i++) begin
      v = v - longint'($urandom_range(0, 3)) * scale - (i == 0);
      vals.push_front(clamp32(v));
    end
    for (int i = 0; i < ne; i++) vals.push_back(lvl);
    v = lvl;
    for (int i = nb + ne; i < n; i++) begin
      v = v + longint'($urandom_range(0, 3)) * scale + (i == nb + ne);
      vals.push_back(clamp32(v));
    end
    foreach (vals[i]) begin
      if (noisy && $urandom_range(0, 5) == 0) vals[i] = longint'($signed($urandom()));
      send_item(vals[i][31:0], 24'($urandom()), i == n - 1);
    end
    features++;
  endtask

  initial begin
    longint lvl, nd;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // defaults straight after reset
    send_item(32'sd5, 24'd0, 1);
    drain();

    // a bin count of one: nothing binned
    set_feature(65535, 2, 1, 3, 3, 0, 0);
    send_item(-32'sd7, 24'd1, 0);
    send_item(32'sd9, 24'd2, 1);
    drain();

    // extremes of values and indices around a zero sparse level
    set_feature(65535, 2, 0, 8, 4, 0, 1);
    send_item(32'h80000000, 24'h000000, 0);
    send_item(32'h80000000, 24'hFFFFFF, 0);
    send_item(32'sd0, 24'h000001, 0);
    send_item(32'h7FFFFFFF, 24'h800000, 1);
    drain();

    // bin not full at the sparse value: indices taken back
    set_feature(1, 2, 0, 16777215, 16777215, 32'sh00010000, 1);
    send_item(-32'sd3, 24'd10, 0);
    send_item(-32'sd2, 24'd11, 0);
    send_item(32'sh00010000, 24'd12, 0);
    send_item(32'sh00010000, 24'd13, 0);
    send_item(32'sh00020000, 24'd14, 1);
    drain();

    // nothing reaches the sparse level, fewer examples than values, min and max bins at the 24-bit limit
    set_feature(65535, 16777215, 16777215, 2, 5, 32'h7FFFFFFF, 1);
    send_item(-32'sd1, 24'd3, 0);
    send_item(32'sd4, 24'd4, 0);
    send_item(32'sd4, 24'd5, 1);
    drain();

    // lowest sparse level, dense mode, single bin per value
    set_feature(65535, 2, 3, 20, 3, 32'h80000000, 0);
    send_item(32'sh80000000, 24'd6, 0);
    send_item(32'sd100, 24'd7, 1);
    drain();

    while (sb.items_seen < 185) begin
      n = $urandom_range(1, 14);
      nd = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : n;
      case ($urandom_range(0, 3))
        0: lvl = 32'sh80000000;
        1: lvl = 32'sh7FFFFFFF;
        default: lvl = longint'($signed($urandom()));
      endcase
      if (lvl[31]) lvl = lvl | ~64'hFFFFFFFF;
      set_feature($urandom_range(1, 65535), $urandom_range(2, 6),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8),
                  nd + $urandom_range(0, 20), nd, lvl, $urandom_range(0, 1));
      tx_eager = ($urandom_range(0, 4) == 0);
      rx_eager = ($urandom_range(0, 4) == 0);
      if (features == 3) begin
        tx_eager = 1;
        hold_off = 300;
        n = 20;
      end
      stream_sorted(n, lvl, $urandom_range(0, 6) == 0);
      tx_eager = 0;
      rx_eager = 0;
      drain();
    end

    $display("%0d features, %0d values in, %0d results checked", features + 6,
             sb.items_seen, sb.results_seen);
    $display("bin counts from one up, dense and sparse modes, extreme levels and values");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("equal_frequency_binner_core verification clean");
    end else begin
      $display("equal_frequency_binner_core verification failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/efb_pkg.sv
design/efb_div.sv
design/equal_frequency_binner_core.sv
design/efb_checker.sv
tb/sv/testbench.sv
